// ----- design/glrt_pkg.sv -----
package glrt_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 7;

   localparam int unsigned NEAR_ROWS = 5;
   localparam int unsigned STEER_REF_SCALE = 100;
   localparam int unsigned STEER_SUM_SCALE = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEER_CENTER      = 3'd0,
      CSR_NARROW_LIMIT      = 3'd1,
      CSR_NEAR_NARROW_LIMIT = 3'd2,
      CSR_EDGE_OFFSET       = 3'd3,
      CSR_DETECT_MIN        = 3'd4,
      CSR_NEAR_MIN          = 3'd5,
      CSR_APPROACH_MIN      = 3'd6,
      CSR_APPROACH_DEPTH    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [5:0] steer_center;
      logic [5:0] narrow_limit;
      logic [5:0] near_narrow_limit;
      logic [5:0] edge_offset;
      logic [6:0] detect_min;
      logic [2:0] near_min;
      logic [6:0] approach_min;
      logic [6:0] approach_depth;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      steer_center:      6'd32,
      narrow_limit:      6'd5,
      near_narrow_limit: 6'd6,
      edge_offset:       6'd5,
      detect_min:        7'd30,
      near_min:          3'd3,
      approach_min:      7'd20,
      approach_depth:    7'd25
   };

   typedef struct packed {
      logic [63:0] row_pixels;
      logic        first_row;
   } req_type;

   typedef struct packed {
      logic signed [13:0] steer_error;
      logic               line_detected;
      logic               line_approaching;
      logic [5:0]         nearest_line_row;
   } rsp_type;

endpackage

// ----- design/glrt_csr.sv -----
module glrt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [glrt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [glrt_pkg::CSR_DATA_W-1:0]    csr_data,
   output glrt_pkg::cfg_type                  cfg
);
   import glrt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEER_CENTER:      cfg_in.steer_center = csr_data[5:0];
            CSR_NARROW_LIMIT:      cfg_in.narrow_limit = csr_data[5:0];
            CSR_NEAR_NARROW_LIMIT: cfg_in.near_narrow_limit = csr_data[5:0];
            CSR_EDGE_OFFSET:       cfg_in.edge_offset = csr_data[5:0];
            CSR_DETECT_MIN:        cfg_in.detect_min = csr_data[6:0];
            CSR_NEAR_MIN:          cfg_in.near_min = csr_data[2:0];
            CSR_APPROACH_MIN:      cfg_in.approach_min = csr_data[6:0];
            CSR_APPROACH_DEPTH:    cfg_in.approach_depth = csr_data[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/glrt_edge.sv -----
module glrt_edge #(
   parameter int COLS = 64,
   localparam int CW = $clog2(COLS)
) (
   input  logic [COLS-1:0] pixels,
   input  logic            filter_en,
   input  logic [5:0]      edge_offset,
   output logic [CW-1:0]   midpoint,
   output logic [CW-1:0]   width
);
   import glrt_pkg::*;

   logic [CW-1:0] start_col;
   logic [CW-1:0] end_col;
   logic [CW-1:0] left;
   logic [CW-1:0] right;
   logic [CW:0]   edge_sum;
   logic [CW-1:0] check_lo;
   logic [CW-1:0] check_hi;
   logic [6:0]    hi_sum;
   logic          collapse;

   // Runs of set pixels touching the row ends are skipped before the edge search.
   always_comb begin
      start_col = CW'(COLS - 1);
      for (int c = COLS - 2; c >= 0; c--) begin
         if (!pixels[c]) begin
            start_col = CW'(c);
         end
      end
   end

   always_comb begin
      end_col = start_col;
      for (int c = 0; c < COLS; c++) begin
         if (c > int'(start_col) && !pixels[c]) begin
            end_col = CW'(c);
         end
      end
   end

   always_comb begin
      left = start_col;
      for (int c = COLS - 1; c >= 1; c--) begin
         if (c > int'(start_col) && c < int'(end_col) && pixels[c] && !pixels[c-1]) begin
            left = CW'(c);
         end
      end
   end

   always_comb begin
      right = end_col;
      for (int c = 0; c <= COLS - 2; c++) begin
         if (c > int'(start_col) && c < int'(end_col) && pixels[c] && !pixels[c+1]) begin
            right = CW'(c);
         end
      end
   end

   assign edge_sum = {1'b0, left} + {1'b0, right};
   assign midpoint = edge_sum[CW:1];

   assign check_lo = (7'(left) >= 7'(edge_offset)) ? CW'(7'(left) - 7'(edge_offset)) : '0;
   assign hi_sum = 7'(right) + 7'(edge_offset);
   assign check_hi = (hi_sum > 7'(COLS - 1)) ? CW'(COLS - 1) : CW'(hi_sum);

   assign collapse = filter_en &&
                     (left == '0 || right == CW'(COLS - 1) || left > right ||
                      pixels[check_lo] || pixels[check_hi]);

   assign width = collapse ? '0 : right - left;

endmodule

// ----- design/glrt_frame.sv -----
module glrt_frame #(
   parameter int ROWS = 64,
   parameter int COLS = 64,
   parameter int WINDOW_FIRST = 40,
   parameter int WINDOW_ROWS = 10,
   localparam int RW = $clog2(ROWS),
   localparam int CW = $clog2(COLS)
) (
   input  logic               clock,
   input  logic               reset,
   input  glrt_pkg::cfg_type  cfg,
   input  logic               advance,
   input  logic               first_row,
   input  logic [CW-1:0]      midpoint,
   input  logic [CW-1:0]      width,
   output logic [RW-1:0]      row,
   output logic               last_row,
   output glrt_pkg::rsp_type  result
);
   import glrt_pkg::*;

   logic [RW-1:0] row_index_ff,        row_index_in;
   logic [RW-1:0] nearest_row_ff,      nearest_row_in;
   logic          nearest_found_ff,    nearest_found_in;
   logic [6:0]    narrow_total_ff,     narrow_total_in;
   logic [2:0]    near_count_ff,       near_count_in;
   logic [6:0]    approach_total_ff,   approach_total_in;
   logic [9:0]    midpoint_sum_ff,     midpoint_sum_in;

   logic [RW-1:0] nearest_row_cur;
   logic          nearest_found_cur;
   logic [6:0]    narrow_total_cur;
   logic [2:0]    near_count_cur;
   logic [6:0]    approach_total_cur;
   logic [9:0]    midpoint_sum_cur;

   logic          in_window;
   logic          near_row;
   logic          width_nonzero;
   logic          narrow;
   logic          near_narrow;
   logic          approach_hit;
   logic          detected;
   logic signed [8:0] approach_bound;
   logic [13:0]   ref_scaled;
   logic [13:0]   sum_scaled;

   // A new frame restarts from the cleared accumulators at the bottom row.
   always_comb begin
      row                = first_row ? RW'(ROWS - 1) : row_index_ff;
      nearest_row_cur    = first_row ? '0 : nearest_row_ff;
      nearest_found_cur  = first_row ? 1'b0 : nearest_found_ff;
      narrow_total_cur   = first_row ? '0 : narrow_total_ff;
      near_count_cur     = first_row ? '0 : near_count_ff;
      approach_total_cur = first_row ? '0 : approach_total_ff;
      midpoint_sum_cur   = first_row ? '0 : midpoint_sum_ff;
   end

   assign last_row = (row == '0);
   assign in_window = int'(row) >= WINDOW_FIRST && int'(row) < WINDOW_FIRST + WINDOW_ROWS;
   assign near_row = int'(row) > ROWS - 1 - int'(NEAR_ROWS);
   assign width_nonzero = (width != '0);
   assign narrow = width_nonzero && (7'(width) < 7'(cfg.narrow_limit));
   assign near_narrow = width_nonzero && (7'(width) < 7'(cfg.near_narrow_limit));
   assign approach_hit = !last_row && narrow;

   always_comb begin
      midpoint_sum_in   = midpoint_sum_cur + (in_window ? 10'(midpoint) : 10'd0);
      narrow_total_in   = narrow_total_cur;
      near_count_in     = near_count_cur;
      approach_total_in = approach_total_cur;
      nearest_row_in    = nearest_row_cur;
      nearest_found_in  = nearest_found_cur;
      if (near_row) begin
         if (near_narrow) begin
            narrow_total_in = narrow_total_cur + 7'd1;
            near_count_in   = near_count_cur + 3'd1;
         end
      end else if (narrow) begin
         narrow_total_in = narrow_total_cur + 7'd1;
      end
      if (approach_hit) begin
         approach_total_in = approach_total_cur + 7'd1;
         if (!nearest_found_cur) begin
            nearest_found_in = 1'b1;
            nearest_row_in   = row;
         end
      end
      row_index_in = last_row ? RW'(ROWS - 1) : row - RW'(1);
   end

   assign approach_bound = 9'(ROWS) - {2'b00, cfg.approach_depth};
   assign detected = (narrow_total_in > cfg.detect_min) && (near_count_in > cfg.near_min);
   assign ref_scaled = 14'(16'(cfg.steer_center) * 16'(STEER_REF_SCALE));
   assign sum_scaled = 14'(16'(midpoint_sum_in) * 16'(STEER_SUM_SCALE));

   always_comb begin
      result.steer_error      = $signed(ref_scaled - sum_scaled);
      result.line_detected    = detected;
      result.line_approaching = !detected &&
                                ($signed({3'b000, 6'(nearest_row_in)}) > approach_bound) &&
                                (approach_total_in > cfg.approach_min);
      result.nearest_line_row = 6'(nearest_row_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_index_ff      <= RW'(ROWS - 1);
         nearest_row_ff    <= '0;
         nearest_found_ff  <= 1'b0;
         narrow_total_ff   <= '0;
         near_count_ff     <= '0;
         approach_total_ff <= '0;
         midpoint_sum_ff   <= '0;
      end else if (advance) begin
         row_index_ff <= row_index_in;
         if (last_row) begin
            nearest_row_ff    <= '0;
            nearest_found_ff  <= 1'b0;
            narrow_total_ff   <= '0;
            near_count_ff     <= '0;
            approach_total_ff <= '0;
            midpoint_sum_ff   <= '0;
         end else begin
            nearest_row_ff    <= nearest_row_in;
            nearest_found_ff  <= nearest_found_in;
            narrow_total_ff   <= narrow_total_in;
            near_count_ff     <= near_count_in;
            approach_total_ff <= approach_total_in;
            midpoint_sum_ff   <= midpoint_sum_in;
         end
      end
   end

endmodule

// ----- design/guide_line_row_tracker_top.sv -----
// One row is accepted per cycle with no bubbles unless a top row waits on a stalled
// full output; the rate is set by the single edge-search and accumulate stage
// between the input register and the result register. Rows other than the top
// row give no result; the top row's result is registered when that row leaves the stage.
// Synchronous active-high reset restores the register defaults and an empty
// frame that expects the bottom row next.
module guide_line_row_tracker_top #(
   parameter int ROWS = 64,
   parameter int COLS = 64,
   parameter int WINDOW_FIRST = 40,
   parameter int WINDOW_ROWS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  glrt_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output glrt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write,
   input  logic [glrt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [glrt_pkg::CSR_DATA_W-1:0]    csr_data
);
   import glrt_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);

   cfg_type       cfg;
   req_type       stage_data_ff;
   logic          stage_valid_ff;
   logic          advance;
   logic [RW-1:0] row;
   logic          last_row;
   logic [CW-1:0] midpoint;
   logic [CW-1:0] width;
   rsp_type       result;
   rsp_type       rsp_data_ff;
   logic          rsp_valid_ff;

   glrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   glrt_edge #(
      .COLS (COLS)
   ) u_edge (
      .pixels      (stage_data_ff.row_pixels[COLS-1:0]),
      .filter_en   (row != '0),
      .edge_offset (cfg.edge_offset),
      .midpoint    (midpoint),
      .width       (width)
   );

   glrt_frame #(
      .ROWS         (ROWS),
      .COLS         (COLS),
      .WINDOW_FIRST (WINDOW_FIRST),
      .WINDOW_ROWS  (WINDOW_ROWS)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .first_row (stage_data_ff.first_row),
      .midpoint  (midpoint),
      .width     (width),
      .row       (row),
      .last_row  (last_row),
      .result    (result)
   );

   // A row leaves the stage unless it carries a result and the output is still full.
   assign advance = stage_valid_ff && (!last_row || !rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && last_row) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_row) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- test/guide_line_row_tracker_top_test.sv -----
module guide_line_row_tracker_top_test;
   import glrt_pkg::*;

   localparam int FRAME_ROWS = 64;
   localparam int ROW_COLS = 64;
   localparam int WIN_FIRST = 40;
   localparam int WIN_ROWS = 10;
   localparam int RANDOM_ROWS = 1550;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [63:0] BORDER = 64'hFF00_0000_0000_00FF;
   localparam logic [63:0] STRIPE = 64'h0000_0001_C000_0000;

   typedef struct packed {
      logic [63:0] pixels;
      logic        first;
      logic [6:0]  count;
      logic        typed;
      rsp_type     want;
   } plan_line_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type cfg_now = CFG_RESET;
   logic [5:0] fr_row;
   logic [5:0] fr_nearest;
   logic fr_found;
   logic [6:0] fr_narrow;
   logic [2:0] fr_near;
   logic [6:0] fr_approach;
   logic [9:0] fr_midsum;

   rsp_type frame_summaries[$];
   plan_line_type row_plan[$];
   int mismatches = 0;
   int frames_seen = 0;
   int rows_sent = 0;
   int cycles = 0;
   int burst_left = 0;
   bit steady = 1'b0;
   bit frame_cut = 1'b0;
   int holdoffs_asked = 0;
   int holdoffs_done = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   guide_line_row_tracker_top #(
      .ROWS(FRAME_ROWS),
      .COLS(ROW_COLS),
      .WINDOW_FIRST(WIN_FIRST),
      .WINDOW_ROWS(WIN_ROWS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic void start_frame();
      fr_row = 6'(FRAME_ROWS - 1);
      fr_nearest = '0;
      fr_found = 1'b0;
      fr_narrow = '0;
      fr_near = '0;
      fr_approach = '0;
      fr_midsum = '0;
   endfunction

   function automatic bit track_row(input req_type item, output rsp_type summary);
      logic [63:0] px;
      int row, s, e, lft, rgt, c, c1, c2, w, err;
      bit hit, det, app;
      px = item.row_pixels;
      summary = '0;
      if (item.first_row)
         start_frame();
      row = int'(fr_row);
      s = 0;
      e = ROW_COLS - 1;
      while (px[s] && s < e)
         s++;
      while (px[e] && e > s)
         e--;
      lft = s;
      hit = 1'b0;
      for (c = s + 1; c < e; c++) begin
         if (!hit && px[c] && !px[c-1]) begin
            lft = c;
            hit = 1'b1;
         end
      end
      rgt = e;
      hit = 1'b0;
      for (c = e - 1; c > s; c--) begin
         if (!hit && px[c] && !px[c+1]) begin
            rgt = c;
            hit = 1'b1;
         end
      end
      if (row >= WIN_FIRST && row < WIN_FIRST + WIN_ROWS)
         fr_midsum = fr_midsum + 10'((lft + rgt) / 2);
      if (row > 0) begin
         c1 = lft - int'(cfg_now.edge_offset);
         c2 = rgt + int'(cfg_now.edge_offset);
         if (c1 < 0)
            c1 = 0;
         if (c2 > ROW_COLS - 1)
            c2 = ROW_COLS - 1;
         if (lft == 0 || rgt == ROW_COLS - 1 || px[c1] || px[c2] || lft > rgt)
            rgt = lft;
      end
      w = rgt - lft;
      if (row >= FRAME_ROWS - int'(NEAR_ROWS)) begin
         if (w < int'(cfg_now.near_narrow_limit) && w != 0) begin
            fr_narrow = fr_narrow + 1'b1;
            fr_near = fr_near + 1'b1;
         end
      end else if (w < int'(cfg_now.narrow_limit) && w != 0) begin
         fr_narrow = fr_narrow + 1'b1;
      end
      if (row > 0 && w < int'(cfg_now.narrow_limit) && w != 0) begin
         fr_approach = fr_approach + 1'b1;
         if (!fr_found) begin
            fr_found = 1'b1;
            fr_nearest = 6'(row);
         end
      end
      if (row == 0) begin
         err = int'(STEER_REF_SCALE) * int'(cfg_now.steer_center)
               - int'(STEER_SUM_SCALE) * int'(fr_midsum);
         det = int'(fr_narrow) > int'(cfg_now.detect_min)
               && int'(fr_near) > int'(cfg_now.near_min);
         app = !det && int'(fr_nearest) > FRAME_ROWS - int'(cfg_now.approach_depth)
               && int'(fr_approach) > int'(cfg_now.approach_min);
         summary.steer_error = err[13:0];
         summary.line_detected = det;
         summary.line_approaching = app;
         summary.nearest_line_row = fr_nearest;
         start_frame();
         return 1'b1;
      end
      fr_row = fr_row - 1'b1;
      return 1'b0;
   endfunction

   function automatic void plan(input logic [63:0] px, input bit first, input int count,
                                input bit typed, input int steer, input int det,
                                input int app, input int nearest);
      plan_line_type ln;
      ln.pixels = px;
      ln.first = first;
      ln.count = 7'(count);
      ln.typed = typed;
      ln.want.steer_error = 14'(steer);
      ln.want.line_detected = det[0];
      ln.want.line_approaching = app[0];
      ln.want.nearest_line_row = 6'(nearest);
      row_plan.push_back(ln);
   endfunction

   function automatic cfg_type pick_regs(input int phase);
      cfg_type c;
      case (phase)
         1: c = '0;
         2: c = '{steer_center: 6'd63, narrow_limit: 6'd63, near_narrow_limit: 6'd63,
                  edge_offset: 6'd63, detect_min: 7'd64, near_min: 3'd5,
                  approach_min: 7'd64, approach_depth: 7'd64};
         3: c = CFG_RESET;
         4: c = '{steer_center: 6'd20, narrow_limit: 6'd8, near_narrow_limit: 6'd8,
                  edge_offset: 6'd3, detect_min: 7'd0, near_min: 3'd0,
                  approach_min: 7'd0, approach_depth: 7'd64};
         default: begin
            c.steer_center = 6'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0) begin
               c.narrow_limit = 6'($urandom_range(0, 63));
               c.near_narrow_limit = 6'($urandom_range(0, 63));
               c.edge_offset = 6'($urandom_range(0, 63));
            end else begin
               c.narrow_limit = 6'($urandom_range(2, 10));
               c.near_narrow_limit = 6'($urandom_range(2, 10));
               c.edge_offset = 6'($urandom_range(1, 8));
            end
            c.detect_min = 7'($urandom_range(0, 48));
            c.near_min = 3'($urandom_range(0, 5));
            c.approach_min = 7'($urandom_range(0, 40));
            c.approach_depth = 7'($urandom_range(0, 64));
         end
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at result %0d: %s got %0d expected %0d",
               frames_seen, what, got, want);
   endtask

   task automatic write_regs(input cfg_type c);
      csr_write <= 1'b1;
      csr_index <= CSR_STEER_CENTER;
      csr_data <= {1'b0, c.steer_center};
      @(posedge clock);
      csr_index <= CSR_NARROW_LIMIT;
      csr_data <= {1'b0, c.narrow_limit};
      @(posedge clock);
      csr_index <= CSR_NEAR_NARROW_LIMIT;
      csr_data <= {1'b0, c.near_narrow_limit};
      @(posedge clock);
      csr_index <= CSR_EDGE_OFFSET;
      csr_data <= {1'b0, c.edge_offset};
      @(posedge clock);
      csr_index <= CSR_DETECT_MIN;
      csr_data <= c.detect_min;
      @(posedge clock);
      csr_index <= CSR_NEAR_MIN;
      csr_data <= {4'b0, c.near_min};
      @(posedge clock);
      csr_index <= CSR_APPROACH_MIN;
      csr_data <= c.approach_min;
      @(posedge clock);
      csr_index <= CSR_APPROACH_DEPTH;
      csr_data <= c.approach_depth;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_now = c;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (frame_summaries.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_row(input req_type item, input bit typed, input rsp_type typed_want);
      int gap;
      rsp_type guess;
      if (!steady) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30)
                                             : $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (req_stall);
      rows_sent++;
      if (track_row(item, guess))
         frame_summaries.push_back(typed ? typed_want : guess);
   endtask

   task automatic send_frame();
      int bl, br, lc, lw, lo, hi, w, c, k, r, rows_out;
      logic [63:0] px;
      req_type item;
      bl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      br = ($urandom_range(0, 3) == 0) ? ROW_COLS - 1 : $urandom_range(49, 62);
      lc = $urandom_range(bl + 8, br - 10);
      lw = $urandom_range(1, 8);
      lo = $urandom_range(0, FRAME_ROWS - 1);
      hi = $urandom_range(lo, FRAME_ROWS - 1);
      if ($urandom_range(0, 2) == 0) begin
         lo = 0;
         hi = FRAME_ROWS - 1;
      end
      rows_out = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_ROWS - 1) : FRAME_ROWS;
      for (k = 0; k < rows_out; k++) begin
         r = FRAME_ROWS - 1 - k;
         px = '0;
         for (c = 0; c < ROW_COLS; c++)
            px[c] = (c < bl || c > br);
         if (r >= lo && r <= hi) begin
            w = lw + $urandom_range(0, 2) - 1;
            if (w < 1)
               w = 1;
            lc = lc + $urandom_range(0, 2) - 1;
            if (lc < bl + 2)
               lc = bl + 2;
            if (lc > br - 10)
               lc = br - 10;
            for (c = lc; c < lc + w && c < ROW_COLS; c++)
               px[c] = 1'b1;
         end
         case ($urandom_range(0, 31))
            0: px = {$urandom, $urandom};
            1: px = '0;
            2: px = '1;
            3: begin
               c = $urandom_range(0, ROW_COLS - 1);
               px[c] = ~px[c];
            end
            default: ;
         endcase
         item.row_pixels = px;
         item.first_row = (k == 0) && (frame_cut || $urandom_range(0, 3) != 0);
         send_row(item, 1'b0, '0);
      end
      frame_cut = rows_out < FRAME_ROWS;
   endtask

   always @(posedge clock) begin : receive
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         frames_seen++;
         if (frame_summaries.size() == 0) begin
            report_mismatch("unexpected result, steer_error",
                            int'($signed(rsp_data.steer_error)), 0);
         end else begin
            want = frame_summaries.pop_front();
            if (rsp_data.steer_error !== want.steer_error)
               report_mismatch("steer_error", int'($signed(rsp_data.steer_error)),
                               int'($signed(want.steer_error)));
            if (rsp_data.line_detected !== want.line_detected)
               report_mismatch("line_detected", int'(rsp_data.line_detected),
                               int'(want.line_detected));
            if (rsp_data.line_approaching !== want.line_approaching)
               report_mismatch("line_approaching", int'(rsp_data.line_approaching),
                               int'(want.line_approaching));
            if (rsp_data.nearest_line_row !== want.nearest_line_row)
               report_mismatch("nearest_line_row", int'(rsp_data.nearest_line_row),
                               int'(want.nearest_line_row));
         end
      end
      if (holdoffs_done != holdoffs_asked) begin
         hold_left = HOLD_CYCLES;
         holdoffs_done++;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= mode_left[2];
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin : main
      req_type item;
      int k, phase, directed_rows;
      start_frame();
      plan(64'h0, 1'b1, 64, 1'b1, 100, 0, 0, 0);
      plan('1, 1'b0, 64, 1'b1, -3100, 0, 0, 0);
      plan(BORDER | STRIPE, 1'b1, 5, 1'b0, 0, 0, 0, 0);
      plan(BORDER | STRIPE | 64'h0000_0000_0200_0000, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'h0000_0000_0000_000C, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'h3000_0000_0000_0000, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'h0000_0000_0000_0001, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'h8000_0000_0000_0000, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'h5555_5555_5555_5555, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(64'h0000_0000_8000_0000, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(BORDER | 64'h0000_01FF_FFF0_0000, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(BORDER, 1'b0, 1, 1'b0, 0, 0, 0, 0);
      plan(BORDER | STRIPE, 1'b1, 64, 1'b0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (row_plan[i]) begin
         item.row_pixels = row_plan[i].pixels;
         for (k = 0; k < int'(row_plan[i].count); k++) begin
            item.first_row = row_plan[i].first && k == 0;
            send_row(item, row_plan[i].typed, row_plan[i].want);
         end
      end
      settle();
      directed_rows = rows_sent;

      phase = 1;
      while (rows_sent - directed_rows < RANDOM_ROWS) begin
         write_regs(pick_regs(phase));
         if (phase == 3) begin
            steady = 1'b1;
            holdoffs_asked++;
         end
         repeat (3) send_frame();
         steady = 1'b0;
         settle();
         phase++;
      end

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
design/glrt_pkg.sv
design/glrt_csr.sv
design/glrt_edge.sv
design/glrt_frame.sv
design/guide_line_row_tracker_top.sv
test/guide_line_row_tracker_top_test.sv
